// ----- design/gcrl_pkg.sv -----
// ----------------------------------------------------------------------------
// Gradient color ramp lookup: shared package
// Sizes, register indexes, item classes and the types passed between units.
// ----------------------------------------------------------------------------
`default_nettype none

package gcrl_pkg;

  localparam int MAX_STOPS = 16;
  localparam int FRAC_BITS = 16;

  localparam int COLOR_W = 32;
  localparam int SLOT_W  = 4;
  localparam int OFF_W   = FRAC_BITS + 1;
  localparam int POS_W   = FRAC_BITS + 2;
  localparam int COUNT_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int ADDR_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int CNT_W  = $clog2(MAX_STOPS + 1);
  localparam int WORD_W = OFF_W + COLOR_W;

  // Channel arithmetic: signed 9-bit difference times unsigned fraction.
  localparam int PROD_W = 9 + FRAC_BITS + 1;
  localparam int SUM_W  = PROD_W + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_COLOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCRETE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOPS       = 2'd3;

  typedef enum logic [2:0] {
    CLS_WRITE,
    CLS_SKIP,
    CLS_LOW,
    CLS_HIGH,
    CLS_WALK
  } item_cls_t;

  typedef struct packed {
    item_cls_t                cls;
    logic [SLOT_W-1:0]        slot;
    logic [OFF_W-1:0]         offset;
    logic [COLOR_W-1:0]       color;
    logic [FRAC_BITS-1:0]     pos;
  } queue_entry_t;

  typedef struct packed {
    logic [COLOR_W-1:0] start_color;
    logic [COLOR_W-1:0] end_color;
    logic               discrete_mode;
    logic [COUNT_W-1:0] stops_in_use;
  } gcrl_cfg_t;

endpackage

`default_nettype wire

// ----- design/gcrl_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gcrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                   wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                   rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/gcrl_front.sv -----
// ----------------------------------------------------------------------------
// Gradient lookup front end
// Classifies an incoming item and packs it into a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module gcrl_front
  import gcrl_pkg::*;
(
  input  wire logic                     func,
  input  wire logic [SLOT_W-1:0]        stop_slot,
  input  wire logic [OFF_W-1:0]         stop_position,
  input  wire logic [COLOR_W-1:0]       stop_rgba,
  input  wire logic signed [POS_W-1:0]  position,
  output queue_entry_t                  entry
);

  localparam logic signed [POS_W-1:0] ONE_POS = POS_W'(1 << FRAC_BITS);

  always_comb begin
    entry.slot   = stop_slot;
    entry.offset = stop_position;
    entry.color  = stop_rgba;
    entry.pos    = position[FRAC_BITS-1:0];
    if (func) begin
      // Writes beyond the table are dropped but still kept in order.
      entry.cls = (32'(stop_slot) < 32'(MAX_STOPS)) ? CLS_WRITE : CLS_SKIP;
    end else if (position <= 0) begin
      entry.cls = CLS_LOW;
    end else if (position >= ONE_POS) begin
      entry.cls = CLS_HIGH;
    end else begin
      entry.cls = CLS_WALK;
    end
  end

endmodule

`default_nettype wire

// ----- design/gcrl_queue.sv -----
// ----------------------------------------------------------------------------
// Gradient lookup item queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gcrl_queue
  import gcrl_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire queue_entry_t push_entry,
  input  wire logic   pop,
  output queue_entry_t head,
  output logic        empty,
  output logic        full
);

  queue_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/gcrl_divider.sv -----
// ----------------------------------------------------------------------------
// Segment fraction divider
// Restoring divider, one quotient bit a cycle: (num << FRAC_BITS) / den.
// ----------------------------------------------------------------------------
`default_nettype none

module gcrl_divider
  import gcrl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [FRAC_BITS-1:0] num,
  input  wire logic [OFF_W-1:0]     den,
  output logic [FRAC_BITS-1:0]      quot,
  output logic                      done
);

  localparam int STEP_W = $clog2(FRAC_BITS);

  logic [OFF_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic              run;
  logic [OFF_W:0]    rem_sh;
  logic              fits;

  // The numerator is below the divisor, so the remainder stays below it too.
  assign rem_sh = {rem, 1'b0};
  assign fits   = (rem_sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= {1'b0, num};
        quot <= '0;
        step <= '0;
        run  <= 1'b1;
      end else if (run) begin
        rem  <= fits ? OFF_W'(rem_sh - {1'b0, den}) : OFF_W'(rem_sh);
        quot <= {quot[FRAC_BITS-2:0], fits};
        step <= step + 1'b1;
        if (step == STEP_W'(FRAC_BITS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/gcrl_back.sv -----
// ----------------------------------------------------------------------------
// Gradient lookup back end
// Executes queued items: stop writes, clamped results, stop walk, fraction and channel blend.
// ----------------------------------------------------------------------------
`default_nettype none

module gcrl_back
  import gcrl_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire gcrl_cfg_t      cfg,
  input  wire queue_entry_t   head,
  input  wire logic           empty,
  output logic                pop,
  output logic                done,
  output logic [COLOR_W-1:0]  rgba
);

  localparam logic [OFF_W-1:0] ONE_OFF = OFF_W'(1 << FRAC_BITS);
  localparam logic [SUM_W-1:0] HALF    = SUM_W'(1 << (FRAC_BITS - 1));

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_EVAL,
    S_DIV,
    S_MUL,
    S_ADD
  } state_t;

  state_t                    state;
  logic [FRAC_BITS-1:0]      pos;
  logic [OFF_W-1:0]          lower;
  logic [OFF_W-1:0]          upper;
  logic [COLOR_W-1:0]        c_lo;
  logic [COLOR_W-1:0]        c_hi;
  logic [CNT_W-1:0]          idx;
  logic                      pend;
  logic [FRAC_BITS-1:0]      frac;
  logic [1:0]                ch;
  logic signed [PROD_W-1:0]  prod;
  logic [COLOR_W-1:0]        acc;

  logic                      ram_we;
  logic [WORD_W-1:0]         ram_rdata;
  logic [OFF_W-1:0]          rd_off;
  logic [COLOR_W-1:0]        rd_col;
  logic [CNT_W-1:0]          n_used;
  logic                      hit;
  logic                      issue;
  logic                      div_start;
  logic                      div_done;
  logic [FRAC_BITS-1:0]      div_quot;
  logic [7:0]                ch_a;
  logic [7:0]                ch_b;
  logic signed [8:0]         ch_diff;
  logic signed [SUM_W-1:0]   ch_sum;
  logic [7:0]                ch_out;
  logic [COLOR_W-1:0]        acc_next;
  logic                      flat;

  assign pop    = (state == S_IDLE) && !empty;
  assign ram_we = pop && (head.cls == CLS_WRITE);

  gcrl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_STOPS)
  ) u_stops (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(head.slot)),
    .wdata ({head.offset, head.color}),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_off = ram_rdata[WORD_W-1 -: OFF_W];
  assign rd_col = ram_rdata[COLOR_W-1:0];

  always_comb begin
    if (32'(cfg.stops_in_use) > 32'(MAX_STOPS)) begin
      n_used = CNT_W'(MAX_STOPS);
    end else begin
      n_used = CNT_W'(cfg.stops_in_use);
    end
  end

  // The read issued last cycle is checked while the next one goes out.
  assign hit   = pend && (rd_off > {1'b0, pos});
  assign issue = !hit && (idx < n_used);

  assign flat      = cfg.discrete_mode || (upper <= lower) || ({1'b0, pos} < lower);
  assign div_start = (state == S_EVAL) && !flat;

  gcrl_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (FRAC_BITS'({1'b0, pos} - lower)),
    .den   (upper - lower),
    .quot  (div_quot),
    .done  (div_done)
  );

  always_comb begin
    ch_a    = c_lo[ch*8 +: 8];
    ch_b    = c_hi[ch*8 +: 8];
    ch_diff = $signed({1'b0, ch_b}) - $signed({1'b0, ch_a});
    ch_sum  = $signed(SUM_W'({ch_a, {FRAC_BITS{1'b0}}})) + $signed({prod[PROD_W-1], prod})
              + $signed(HALF);
    ch_out  = ch_sum[FRAC_BITS+7:FRAC_BITS];
    acc_next = acc;
    acc_next[ch*8 +: 8] = ch_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            case (head.cls)
              CLS_LOW: begin
                done <= 1'b1;
                rgba <= cfg.start_color;
              end
              CLS_HIGH: begin
                done <= 1'b1;
                rgba <= cfg.end_color;
              end
              CLS_WALK: begin
                pos   <= head.pos;
                lower <= '0;
                upper <= ONE_OFF;
                c_lo  <= cfg.start_color;
                c_hi  <= cfg.end_color;
                idx   <= '0;
                pend  <= 1'b0;
                state <= S_WALK;
              end
              default: begin
              end
            endcase
          end
        end
        S_WALK: begin
          if (pend) begin
            if (hit) begin
              upper <= rd_off;
              c_hi  <= rd_col;
            end else begin
              lower <= rd_off;
              c_lo  <= rd_col;
            end
          end
          pend <= issue;
          if (issue) begin
            idx <= idx + 1'b1;
          end
          if (hit || (!pend && !issue)) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (flat) begin
            done  <= 1'b1;
            rgba  <= c_lo;
            state <= S_IDLE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            frac  <= div_quot;
            ch    <= 2'd3;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= ch_diff * $signed({1'b0, frac});
          state <= S_ADD;
        end
        S_ADD: begin
          acc <= acc_next;
          if (ch == 2'd0) begin
            done  <= 1'b1;
            rgba  <= acc_next;
            state <= S_IDLE;
          end else begin
            ch    <= ch - 1'b1;
            state <= S_MUL;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/gradient_color_ramp_lookup_core.sv -----
// ----------------------------------------------------------------------------
// Gradient color ramp lookup core
// Maps a signed Q1.16 position to an RGBA color through a table of gradient stops.
// ----------------------------------------------------------------------------
// Result steps: a clamped lookup returns the start or end color straight from the queue head;
// a blend walks the used stops, one table read a stop, stopping early if a stop closes the
// segment, then runs the divider and the four-channel blend; discrete mode or an empty
// segment skips those two. A stop write lands in the table when the back end pops it.
// Throughput: one item at a time behind a two-entry queue, the next starting in the done cycle.
// Reset empties the queue and loads the register defaults, not the table; no result stall.
`default_nettype none

module gradient_color_ramp_lookup_core
  import gcrl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     func,
  input  wire logic [SLOT_W-1:0]        stop_slot,
  input  wire logic [OFF_W-1:0]         stop_position,
  input  wire logic [COLOR_W-1:0]       stop_rgba,
  input  wire logic signed [POS_W-1:0]  position,
  output logic                          done,
  output logic [COLOR_W-1:0]            rgba,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]    cfg_wdata
);

  gcrl_cfg_t    cfg;
  queue_entry_t front_entry;
  queue_entry_t head;
  logic         q_empty;
  logic         q_full;
  logic         pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_color   <= '0;
      cfg.end_color     <= '1;
      cfg.discrete_mode <= 1'b0;
      cfg.stops_in_use  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_START_COLOR: cfg.start_color   <= cfg_wdata[COLOR_W-1:0];
        CFG_END_COLOR:   cfg.end_color     <= cfg_wdata[COLOR_W-1:0];
        CFG_DISCRETE:    cfg.discrete_mode <= cfg_wdata[0];
        CFG_STOPS:       cfg.stops_in_use  <= cfg_wdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign busy = q_full;

  gcrl_front u_front (
    .func          (func),
    .stop_slot     (stop_slot),
    .stop_position (stop_position),
    .stop_rgba     (stop_rgba),
    .position      (position),
    .entry         (front_entry)
  );

  gcrl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (start && !q_full),
    .push_entry (front_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  gcrl_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .head  (head),
    .empty (q_empty),
    .pop   (pop),
    .done  (done),
    .rgba  (rgba)
  );

endmodule

`default_nettype wire

// ----- design/gcrl_checker.sv -----
// ----------------------------------------------------------------------------
// Gradient lookup port checker
// Watches the top-level ports for reset, queue and result-count slips.
// ----------------------------------------------------------------------------
`default_nettype none

module gcrl_checker
  import gcrl_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic func,
  input wire logic done
);

  // Lookups accepted whose color has not yet come out.
  logic [2:0] outstanding;
  logic       lookup_in;

  assign lookup_in = start && !busy && !func;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 3'(lookup_in) - 3'(done);
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("busy or done high right after reset");

  a_busy_needs_transfer: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without a transfer");

  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> (outstanding != 3'd0))
    else $error("result without an outstanding lookup");

  a_outstanding_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 3'(QUEUE_DEPTH + 1))
    else $error("more lookups in flight than the queue and back end hold");

endmodule

bind gradient_color_ramp_lookup_core gcrl_checker u_gcrl_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .func  (func),
  .done  (done)
);

`default_nettype wire
